/* src/assert_macros.svh */
// assertion macros shared by the crossover signal rtl
// no dependencies; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/macs_pkg.sv */
// shared constants and types of the moving-average crossover signal block
// no dependencies; imported by the interfaces and every module
`timescale 1ns / 1ps
`default_nettype none

package macs_pkg;

   localparam int DEF_MAX_WINDOW = 256;
   localparam int DEF_PRICE_BITS = 32;

   localparam int CSR_DATA_W = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int SIGNAL_W   = 2;

   localparam logic [CSR_DATA_W-1:0] DEF_SHORT_WINDOW = 9'd5;
   localparam logic [CSR_DATA_W-1:0] DEF_LONG_WINDOW  = 9'd20;

   // register indexes; the upper two are unmapped and ignored
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHORT_WINDOW,
      CSR_LONG_WINDOW,
      CSR_SPARE_2,
      CSR_SPARE_3
   } csr_idx_type;

   typedef enum logic [SIGNAL_W-1:0] {
      SIG_HOLD,
      SIG_BUY,
      SIG_SELL
   } sig_type;

   // relation of the short average to the long one
   typedef enum logic [1:0] {
      REL_NONE,
      REL_BELOW,
      REL_EQUAL,
      REL_ABOVE
   } rel_type;

   // per-word flags that ride the pipe from the front end to the decision stage
   typedef struct packed {
      logic warm;         // fewer than long_window prices seen
      logic short_full;   // at least short_window prices seen
   } macs_flags_type;

endpackage

`default_nettype wire

/* src/macs_if.sv */
// valid/ready channel interfaces for price words in and signal words out
// depends on macs_pkg
`timescale 1ns / 1ps
`default_nettype none

interface macs_req_if import macs_pkg::*; #(
   parameter int PRICE_BITS = DEF_PRICE_BITS
) ();
   logic                  valid;
   logic                  ready;
   logic [PRICE_BITS-1:0] close_price;

   modport source (output valid, output close_price, input ready);
   modport sink   (input valid, input close_price, output ready);
endinterface

interface macs_rsp_if import macs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SIGNAL_W-1:0] signal;
   logic                warming_up;

   modport source (output valid, output signal, output warming_up, input ready);
   modport sink   (input valid, input signal, input warming_up, output ready);
endinterface

`default_nettype wire

/* src/macs_ring.sv */
// price ring memory: one write port, two registered read ports, read-first
// depends on macs_pkg
`timescale 1ns / 1ps
`default_nettype none

module macs_ring import macs_pkg::*; #(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int PRICE_BITS = DEF_PRICE_BITS,
   localparam int AW = $clog2(MAX_WINDOW)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire logic [PRICE_BITS-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [AW-1:0]         rd_addr_a,
   input  wire logic [AW-1:0]         rd_addr_b,
   output logic      [PRICE_BITS-1:0] rd_data_a_ff,
   output logic      [PRICE_BITS-1:0] rd_data_b_ff
);

   // read data is only used for entries written since the last restart
   logic [PRICE_BITS-1:0] mem [MAX_WINDOW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // a full-depth window reads the slot being overwritten: old data wins
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

/* src/macs_front.sv */
// front end: window registers, ring pointers, ring access and the two running sums
// depends on macs_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module macs_front import macs_pkg::*; #(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int PRICE_BITS = DEF_PRICE_BITS,
   localparam int AW    = $clog2(MAX_WINDOW),
   localparam int CNT_W = $clog2(MAX_WINDOW + 1),
   localparam int SUM_W = PRICE_BITS + $clog2(MAX_WINDOW)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [PRICE_BITS-1:0] in_price,
   output logic                       ring_wr_en,
   output logic      [AW-1:0]         ring_wr_addr,
   output logic      [PRICE_BITS-1:0] ring_wr_data,
   output logic                       ring_rd_en,
   output logic      [AW-1:0]         ring_rd_addr_a,
   output logic      [AW-1:0]         ring_rd_addr_b,
   input  wire logic [PRICE_BITS-1:0] ring_rd_data_a,
   input  wire logic [PRICE_BITS-1:0] ring_rd_data_b,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic      [SUM_W-1:0]      short_sum,
   output logic      [SUM_W-1:0]      long_sum,
   output macs_flags_type             out_flags,
   output logic      [CNT_W-1:0]      short_win,
   output logic      [CNT_W-1:0]      long_win,
   output logic                       restart
);

   localparam int EW = CNT_W + 1;

   function automatic logic [CNT_W-1:0] clamp_win(input logic [CSR_DATA_W-1:0] w);
      logic [31:0] wide;
      wide = 32'(w);
      if (wide == 32'd0) return CNT_W'(1);
      if (wide > 32'(MAX_WINDOW)) return CNT_W'(MAX_WINDOW);
      return CNT_W'(wide);
   endfunction

   // slot that lies win entries behind the write pointer
   function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] wp,
                                               input logic [CNT_W-1:0] win);
      logic [EW-1:0] wpe;
      logic [EW-1:0] we;
      wpe = EW'(wp);
      we  = EW'(win);
      if (wpe >= we) return AW'(wpe - we);
      return AW'(wpe + EW'(MAX_WINDOW) - we);
   endfunction

   logic [CNT_W-1:0]      short_win_ff, long_win_ff;
   logic [AW-1:0]         wp_ff, wp_in;
   logic [CNT_W-1:0]      seen_ff, seen_in;
   logic                  v1_ff, v2_ff;
   logic [PRICE_BITS-1:0] price1_ff;
   logic                  sub_s1_ff, sub_l1_ff;
   macs_flags_type        flags1_ff, flags2_ff, flags1_in;
   logic [SUM_W-1:0]      short_sum_ff, long_sum_ff, short_sum_in, long_sum_in;
   logic                  accept, move1, move2, ready2;

   assign restart = csr_write_en &&
                    (csr_index == CSR_SHORT_WINDOW || csr_index == CSR_LONG_WINDOW);

   // bubbles collapse: each stage fills when empty or draining
   assign move2    = v2_ff && out_ready;
   assign ready2   = !v2_ff || out_ready;
   assign move1    = v1_ff && ready2;
   assign in_ready = !v1_ff || ready2;
   assign accept   = in_valid && in_ready;

   assign wp_in   = (wp_ff == AW'(MAX_WINDOW - 1)) ? '0 : wp_ff + AW'(1);
   assign seen_in = (seen_ff == CNT_W'(MAX_WINDOW)) ? seen_ff : seen_ff + CNT_W'(1);

   always_comb begin
      flags1_in.warm       = seen_in < long_win_ff;
      flags1_in.short_full = seen_in >= short_win_ff;
   end

   assign ring_wr_en     = accept;
   assign ring_wr_addr   = wp_ff;
   assign ring_wr_data   = in_price;
   assign ring_rd_en     = accept;
   assign ring_rd_addr_a = back_addr(wp_ff, short_win_ff);
   assign ring_rd_addr_b = back_addr(wp_ff, long_win_ff);

   assign short_sum_in = short_sum_ff - (sub_s1_ff ? SUM_W'(ring_rd_data_a) : '0)
                         + SUM_W'(price1_ff);
   assign long_sum_in  = long_sum_ff - (sub_l1_ff ? SUM_W'(ring_rd_data_b) : '0)
                         + SUM_W'(price1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         short_win_ff <= clamp_win(DEF_SHORT_WINDOW);
         long_win_ff  <= clamp_win(DEF_LONG_WINDOW);
         wp_ff        <= '0;
         seen_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         short_sum_ff <= '0;
         long_sum_ff  <= '0;
      end else begin
         if (csr_write_en && csr_index == CSR_SHORT_WINDOW) begin
            short_win_ff <= clamp_win(csr_wdata);
         end
         if (csr_write_en && csr_index == CSR_LONG_WINDOW) begin
            long_win_ff <= clamp_win(csr_wdata);
         end
         if (restart) begin
            wp_ff        <= '0;
            seen_ff      <= '0;
            short_sum_ff <= '0;
            long_sum_ff  <= '0;
         end else begin
            if (accept) begin
               wp_ff   <= wp_in;
               seen_ff <= seen_in;
            end
            if (move1) begin
               short_sum_ff <= short_sum_in;
               long_sum_ff  <= long_sum_in;
            end
         end
         if (accept) begin
            v1_ff <= 1'b1;
         end else if (move1) begin
            v1_ff <= 1'b0;
         end
         if (move1) begin
            v2_ff <= 1'b1;
         end else if (move2) begin
            v2_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         price1_ff <= in_price;
         sub_s1_ff <= seen_ff >= short_win_ff;
         sub_l1_ff <= seen_ff >= long_win_ff;
         flags1_ff <= flags1_in;
      end
      if (move1) begin
         flags2_ff <= flags1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign short_sum = short_sum_ff;
   assign long_sum  = long_sum_ff;
   assign out_flags = flags2_ff;
   assign short_win = short_win_ff;
   assign long_win  = long_win_ff;

   `ASSERT_IMPLIES(a_seen_tracks_wp, clock, reset, seen_ff < CNT_W'(MAX_WINDOW), CNT_W'(wp_ff) == seen_ff, "write pointer and fill count disagree")
   `ASSERT_NEXT(a_stage1_holds, clock, reset, v1_ff && !ready2 && !restart, v1_ff && $stable(price1_ff), "stalled word lost in stage 1")

endmodule

`default_nettype wire

/* src/macs_decide.sv */
// decision stage: cross-multiplied compare, crossover state and output register
// depends on macs_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module macs_decide import macs_pkg::*; #(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int PRICE_BITS = DEF_PRICE_BITS,
   localparam int CNT_W  = $clog2(MAX_WINDOW + 1),
   localparam int SUM_W  = PRICE_BITS + $clog2(MAX_WINDOW),
   localparam int PROD_W = SUM_W + CNT_W
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                restart,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [SUM_W-1:0]    short_sum,
   input  wire logic [SUM_W-1:0]    long_sum,
   input  wire macs_flags_type      in_flags,
   input  wire logic [CNT_W-1:0]    short_win,
   input  wire logic [CNT_W-1:0]    long_win,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic      [SIGNAL_W-1:0] out_signal,
   output logic                     out_warming_up
);

   logic              v3_ff, warm3_ff;
   logic [PROD_W-1:0] prod_s_ff, prod_l_ff;
   logic [SUM_W-1:0]  short_used;
   rel_type           rel, prev_rel_ff, prev_rel_in;
   logic              holding_ff, holding_in;
   sig_type           sig_in;
   logic              out_valid_ff, out_warm_ff;
   sig_type           out_sig_ff;
   logic              ready_out, move2, move3;

   assign ready_out = !out_valid_ff || out_ready;
   assign move3     = v3_ff && ready_out;
   assign in_ready  = !v3_ff || ready_out;
   assign move2     = in_valid && in_ready;

   // short average counts as zero until its window has filled
   assign short_used = in_flags.short_full ? short_sum : '0;

   always_comb begin
      priority if (prod_s_ff < prod_l_ff) begin
         rel = REL_BELOW;
      end else if (prod_s_ff == prod_l_ff) begin
         rel = REL_EQUAL;
      end else begin
         rel = REL_ABOVE;
      end
   end

   always_comb begin
      sig_in      = SIG_HOLD;
      holding_in  = holding_ff;
      prev_rel_in = prev_rel_ff;
      if (!warm3_ff) begin
         if (rel == REL_ABOVE && (prev_rel_ff == REL_BELOW || prev_rel_ff == REL_EQUAL)
             && !holding_ff) begin
            sig_in     = SIG_BUY;
            holding_in = 1'b1;
         end else if (rel == REL_BELOW
                      && (prev_rel_ff == REL_ABOVE || prev_rel_ff == REL_EQUAL)
                      && holding_ff) begin
            sig_in     = SIG_SELL;
            holding_in = 1'b0;
         end
         prev_rel_in = rel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         prev_rel_ff  <= REL_NONE;
         holding_ff   <= 1'b0;
      end else begin
         if (move2) begin
            v3_ff <= 1'b1;
         end else if (move3) begin
            v3_ff <= 1'b0;
         end
         if (move3) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (restart) begin
            prev_rel_ff <= REL_NONE;
         end else if (move3) begin
            prev_rel_ff <= prev_rel_in;
         end
         if (move3) begin
            holding_ff <= holding_in;
         end
      end
   end

   // averages compared as short_sum * long_win against long_sum * short_win
   always_ff @(posedge clock) begin
      if (move2) begin
         prod_s_ff <= PROD_W'(short_used) * PROD_W'(long_win);
         prod_l_ff <= PROD_W'(long_sum) * PROD_W'(short_win);
         warm3_ff  <= in_flags.warm;
      end
      if (move3) begin
         out_sig_ff  <= sig_in;
         out_warm_ff <= warm3_ff;
      end
   end

   assign out_valid      = out_valid_ff;
   assign out_signal     = out_sig_ff;
   assign out_warming_up = out_warm_ff;

   `ASSERT_NEXT(a_buy_enters, clock, reset, move3 && sig_in == SIG_BUY, holding_ff, "buy did not open a position")
   `ASSERT_NEXT(a_sell_leaves, clock, reset, move3 && sig_in == SIG_SELL, !holding_ff, "sell did not close the position")
   `ASSERT_IMPLIES(a_warm_holds, clock, reset, out_valid_ff && out_warm_ff, out_sig_ff == SIG_HOLD, "trade signal during warm-up")

endmodule

`default_nettype wire

/* src/ma_crossover_signal_top.sv */
// top level of the dual moving-average crossover signal block
// depends on macs_pkg, macs_if, macs_ring, macs_front and macs_decide
//
//   channel   dir   word                      handshake
//   req_bus   in    close_price               valid/ready
//   rsp_bus   out   signal, warming_up        valid/ready
//   csr_*     in    short/long window write   write enable, no wait
//
// one price word per cycle sustained while rsp_bus is not stalled
// the rate is set by the running-sum registers, updated once per word from the ring reads
// reset clears pointers, counts, sums and crossover state; the ring itself is not swept
// stalls on rsp_bus fill the internal stages before req_bus.ready drops
`timescale 1ns / 1ps
`default_nettype none

module ma_crossover_signal_top import macs_pkg::*; #(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int PRICE_BITS = DEF_PRICE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   macs_req_if.sink                   req_bus,
   macs_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW    = $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = PRICE_BITS + $clog2(MAX_WINDOW);

   logic                  ring_wr_en, ring_rd_en;
   logic [AW-1:0]         ring_wr_addr, ring_rd_addr_a, ring_rd_addr_b;
   logic [PRICE_BITS-1:0] ring_wr_data, ring_rd_data_a, ring_rd_data_b;
   logic                  mid_valid, mid_ready, restart;
   logic [SUM_W-1:0]      short_sum, long_sum;
   macs_flags_type        mid_flags;
   logic [CNT_W-1:0]      short_win, long_win;

   macs_front #(
      .MAX_WINDOW (MAX_WINDOW),
      .PRICE_BITS (PRICE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .in_valid       (req_bus.valid),
      .in_ready       (req_bus.ready),
      .in_price       (req_bus.close_price),
      .ring_wr_en     (ring_wr_en),
      .ring_wr_addr   (ring_wr_addr),
      .ring_wr_data   (ring_wr_data),
      .ring_rd_en     (ring_rd_en),
      .ring_rd_addr_a (ring_rd_addr_a),
      .ring_rd_addr_b (ring_rd_addr_b),
      .ring_rd_data_a (ring_rd_data_a),
      .ring_rd_data_b (ring_rd_data_b),
      .out_valid      (mid_valid),
      .out_ready      (mid_ready),
      .short_sum      (short_sum),
      .long_sum       (long_sum),
      .out_flags      (mid_flags),
      .short_win      (short_win),
      .long_win       (long_win),
      .restart        (restart)
   );

   macs_ring #(
      .MAX_WINDOW (MAX_WINDOW),
      .PRICE_BITS (PRICE_BITS)
   ) u_ring (
      .clock        (clock),
      .wr_en        (ring_wr_en),
      .wr_addr      (ring_wr_addr),
      .wr_data      (ring_wr_data),
      .rd_en        (ring_rd_en),
      .rd_addr_a    (ring_rd_addr_a),
      .rd_addr_b    (ring_rd_addr_b),
      .rd_data_a_ff (ring_rd_data_a),
      .rd_data_b_ff (ring_rd_data_b)
   );

   macs_decide #(
      .MAX_WINDOW (MAX_WINDOW),
      .PRICE_BITS (PRICE_BITS)
   ) u_decide (
      .clock          (clock),
      .reset          (reset),
      .restart        (restart),
      .in_valid       (mid_valid),
      .in_ready       (mid_ready),
      .short_sum      (short_sum),
      .long_sum       (long_sum),
      .in_flags       (mid_flags),
      .short_win      (short_win),
      .long_win       (long_win),
      .out_valid      (rsp_bus.valid),
      .out_ready      (rsp_bus.ready),
      .out_signal     (rsp_bus.signal),
      .out_warming_up (rsp_bus.warming_up)
   );

endmodule

`default_nettype wire
